// ----- hdl/ids_pkg.sv -----
package ids_pkg;

	localparam int unsigned DEPTH_DEF      = 16;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_END   = 3'd1,
		FN_PEEK       = 3'd2,
		FN_POP        = 3'd3,
		FN_READ       = 3'd4,
		FN_WRITE      = 3'd5,
		FN_SWAP       = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SWAP_A,
		S_SWAP_B
	} state_t;

	// result register controls from the sequencer
	typedef struct packed {
		logic take_meta;
		logic take_data;
		logic fire;
	} res_ctl_t;

endpackage

// ----- hdl/ids_ram.sv -----
module ids_ram #(
	parameter int unsigned WIDTH = ids_pkg::DATA_WIDTH_DEF,
	parameter int unsigned DEPTH = ids_pkg::DEPTH_DEF,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wa,
	input  logic [WIDTH-1:0] wd,
	input  logic             re_a,
	input  logic [AW-1:0]    ra,
	output logic [WIDTH-1:0] rd_a,
	input  logic             re_b,
	input  logic [AW-1:0]    rb,
	output logic [WIDTH-1:0] rd_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re_a) begin
			rd_a_q <= mem[ra];
		end
		if (re_b) begin
			rd_b_q <= mem[rb];
		end
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule

// ----- hdl/ids_ctrl.sv -----
module ids_ctrl #(
	parameter int unsigned DEPTH      = ids_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = ids_pkg::DATA_WIDTH_DEF,
	localparam int unsigned AW        = $clog2(DEPTH),
	localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0]            func,
	input  logic [DATA_WIDTH-1:0] data_in,
	input  logic [AW-1:0]         index_a,
	input  logic [AW-1:0]         index_b,
	output logic                  busy,
	output logic                  mem_we,
	output logic [AW-1:0]         mem_wa,
	output logic [DATA_WIDTH-1:0] mem_wd,
	output logic                  mem_re_a,
	output logic [AW-1:0]         mem_ra,
	output logic                  mem_re_b,
	output logic [AW-1:0]         mem_rb,
	input  logic [DATA_WIDTH-1:0] mem_rd_a,
	input  logic [DATA_WIDTH-1:0] mem_rd_b,
	output ids_pkg::res_ctl_t     res,
	output logic [CW-1:0]         res_count,
	output ids_pkg::status_t      res_status
);

	ids_pkg::state_t  state_q, state_d;
	ids_pkg::func_t   fn;
	ids_pkg::status_t st;
	logic [AW-1:0]    front_q, front_nxt;
	logic [CW-1:0]    count_q, cnt_nxt;
	logic [AW-1:0]    sa_q, sb_q;
	logic [AW-1:0]    slot_a, slot_b, slot_end, front_dec, front_inc;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic             full, empty, a_ok, b_ok;
	logic             go_read, go_swap, wr_en, accept;

	// (base + pos) mod DEPTH, both operands below DEPTH
	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [AW-1:0] pos);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, pos};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign fn        = ids_pkg::func_t'(func);
	assign accept    = start && (state_q == ids_pkg::S_IDLE);
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign a_ok      = (CW'(index_a) < count_q);
	assign b_ok      = (CW'(index_b) < count_q);
	assign slot_a    = wrap(front_q, index_a);
	assign slot_b    = wrap(front_q, index_b);
	assign slot_end  = wrap(front_q, AW'(count_q));
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

	// request decode against the current pointers
	always_comb begin
		st        = ids_pkg::ST_OK;
		go_read   = 1'b0;
		go_swap   = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = slot_a;
		rd_addr   = slot_a;
		cnt_nxt   = count_q;
		front_nxt = front_q;
		case (fn)
			ids_pkg::FN_PUSH_FRONT: begin
				if (full) begin
					st = ids_pkg::ST_FULL;
				end else begin
					wr_en     = 1'b1;
					wr_addr   = front_dec;
					front_nxt = front_dec;
					cnt_nxt   = count_q + CW'(1);
				end
			end
			ids_pkg::FN_PUSH_END: begin
				if (full) begin
					st = ids_pkg::ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = slot_end;
					cnt_nxt = count_q + CW'(1);
				end
			end
			ids_pkg::FN_PEEK, ids_pkg::FN_POP: begin
				if (empty) begin
					st = ids_pkg::ST_EMPTY;
				end else begin
					go_read = 1'b1;
					rd_addr = front_q;
					if (fn == ids_pkg::FN_POP) begin
						front_nxt = front_inc;
						cnt_nxt   = count_q - CW'(1);
					end
				end
			end
			ids_pkg::FN_READ: begin
				if (!a_ok) begin
					st = ids_pkg::ST_RANGE;
				end else begin
					go_read = 1'b1;
				end
			end
			ids_pkg::FN_WRITE: begin
				if (!a_ok) begin
					st = ids_pkg::ST_RANGE;
				end else begin
					wr_en = 1'b1;
				end
			end
			ids_pkg::FN_SWAP: begin
				if (!(a_ok && b_ok)) begin
					st = ids_pkg::ST_RANGE;
				end else if (index_a != index_b) begin
					go_swap = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ids_pkg::S_IDLE: begin
				if (start) begin
					if (go_read) begin
						state_d = ids_pkg::S_READ;
					end else if (go_swap) begin
						state_d = ids_pkg::S_SWAP_A;
					end
				end
			end
			ids_pkg::S_READ:   state_d = ids_pkg::S_IDLE;
			ids_pkg::S_SWAP_A: state_d = ids_pkg::S_SWAP_B;
			ids_pkg::S_SWAP_B: state_d = ids_pkg::S_IDLE;
			default:           state_d = ids_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy       = (state_q != ids_pkg::S_IDLE);
		mem_we     = 1'b0;
		mem_wa     = wr_addr;
		mem_wd     = data_in;
		mem_re_a   = 1'b0;
		mem_ra     = rd_addr;
		mem_re_b   = 1'b0;
		mem_rb     = slot_b;
		res        = '0;
		res_count  = cnt_nxt;
		res_status = st;
		case (state_q)
			ids_pkg::S_IDLE: begin
				if (start) begin
					mem_we        = wr_en;
					mem_re_a      = go_read || go_swap;
					mem_re_b      = go_swap;
					res.take_meta = 1'b1;
					res.fire      = !(go_read || go_swap);
				end
			end
			ids_pkg::S_READ: begin
				res.take_data = 1'b1;
				res.fire      = 1'b1;
			end
			// swap: both words were read together, written back one a cycle
			ids_pkg::S_SWAP_A: begin
				mem_we = 1'b1;
				mem_wa = sa_q;
				mem_wd = mem_rd_b;
			end
			ids_pkg::S_SWAP_B: begin
				mem_we   = 1'b1;
				mem_wa   = sb_q;
				mem_wd   = mem_rd_a;
				res.fire = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ids_pkg::S_IDLE;
			front_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				front_q <= front_nxt;
				count_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sa_q <= slot_a;
			sb_q <= slot_b;
		end
	end

endmodule

// ----- hdl/indexed_deque_store_core.sv -----
// push, write, errors and no-op fire from S_IDLE; peek, pop and read pass through S_READ;
// swap goes through S_SWAP_A then S_SWAP_B. No new request is taken while busy, due to the registered
// memory read and the single write port that a swap uses twice
// results are strobed by done for one cycle; the receiver cannot stall
// reset clears the front pointer and entry count; memory contents are left undefined
module indexed_deque_store_core #(
	parameter int unsigned DEPTH      = ids_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = ids_pkg::DATA_WIDTH_DEF,
	localparam int unsigned AW        = $clog2(DEPTH),
	localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            func,
	input  logic [DATA_WIDTH-1:0] data_in,
	input  logic [AW-1:0]         index_a,
	input  logic [AW-1:0]         index_b,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] data_out,
	output logic [CW-1:0]         entry_count,
	output logic [1:0]            status
);

	logic                  mem_we, mem_re_a, mem_re_b;
	logic [AW-1:0]         mem_wa, mem_ra, mem_rb;
	logic [DATA_WIDTH-1:0] mem_wd, mem_rd_a, mem_rd_b;
	ids_pkg::res_ctl_t     res;
	logic [CW-1:0]         res_count;
	ids_pkg::status_t      res_status;

	logic                  done_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [CW-1:0]         cnt_q;
	ids_pkg::status_t      status_q;

	ids_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.wa   (mem_wa),
		.wd   (mem_wd),
		.re_a (mem_re_a),
		.ra   (mem_ra),
		.rd_a (mem_rd_a),
		.re_b (mem_re_b),
		.rb   (mem_rb),
		.rd_b (mem_rd_b)
	);

	ids_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.func       (func),
		.data_in    (data_in),
		.index_a    (index_a),
		.index_b    (index_b),
		.busy       (busy),
		.mem_we     (mem_we),
		.mem_wa     (mem_wa),
		.mem_wd     (mem_wd),
		.mem_re_a   (mem_re_a),
		.mem_ra     (mem_ra),
		.mem_re_b   (mem_re_b),
		.mem_rb     (mem_rb),
		.mem_rd_a   (mem_rd_a),
		.mem_rd_b   (mem_rd_b),
		.res        (res),
		.res_count  (res_count),
		.res_status (res_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.fire;
		end
	end

	// data word is zero unless a read fills it in
	always_ff @(posedge clk) begin
		if (res.take_meta) begin
			cnt_q    <= res_count;
			status_q <= res_status;
			data_q   <= '0;
		end else if (res.take_data) begin
			data_q <= mem_rd_a;
		end
	end

	assign done        = done_q;
	assign data_out    = data_q;
	assign entry_count = cnt_q;
	assign status      = status_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while still busy");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted word produced neither result nor busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (entry_count <= CW'(DEPTH)))
		else $error("entry count above depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ids_pkg::ST_FULL)) |-> (entry_count == CW'(DEPTH)))
		else $error("full status without full count");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ids_pkg::ST_EMPTY)) |-> (entry_count == '0))
		else $error("empty status with nonzero count");

endmodule
